@@ rtl/core/sio_cfg_pkg.sv @@
// Shared types and constants for the Super I/O configuration port.
// Holds register addresses, key defaults and the controller/datapath command
// and status structs. No dependencies.
`timescale 1ns / 1ps

package sio_cfg_pkg;

  typedef logic [7:0] byte_t;

  // Global register file is fixed at 0x00..0x2f
  localparam int unsigned GLOBAL_REG_COUNT = 48;
  localparam int unsigned GLB_AW           = 6;

  // Register addresses
  localparam byte_t REG_LDN      = 8'h07;
  localparam byte_t REG_VENDOR   = 8'h20;
  localparam byte_t REG_REVISION = 8'h21;
  localparam byte_t REG_GLB_FF   = 8'h22;
  localparam byte_t DEV_BASE     = 8'h30;
  localparam byte_t REG_ACTIVATE = 8'h30;
  localparam byte_t REG_BASE_HI  = 8'h60;
  localparam byte_t REG_BASE_LO  = 8'h61;
  localparam byte_t REG_IRQ      = 8'h70;

  // Reset values
  localparam byte_t GLB_FF_RST   = 8'hff;
  localparam byte_t LOCK_KEY_RST = 8'haa;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VENDOR_ID   = 2'd0,
    CFG_REVISION_ID = 2'd1,
    CFG_LOCK_KEY    = 2'd2,
    CFG_UNLOCK_KEY  = 2'd3
  } cfg_reg_e;

  // Stream payload widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 32;

  // Controller -> datapath commands
  typedef struct packed {
    logic clear;   // clearing pass: write one device entry (and one global entry while in range)
    logic accept;  // input transfer this cycle
    logic load;    // load result register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic clear_done;  // last entry of the clearing pass is being written
  } sts_t;

endpackage

@@ rtl/core/sio_cfg_ctrl.sv @@
// Sequencer for the Super I/O configuration port.
// Runs the post-reset clearing pass, then accept / execute / present per access.
// Depends on sio_cfg_pkg.
`timescale 1ns / 1ps

module sio_cfg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  input  sio_cfg_pkg::sts_t sts_i,
  output sio_cfg_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   s_tready_q;
  logic   m_tvalid_q;
  logic   accept;

  assign accept = s_tvalid_i && s_tready_q;

  // State and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      s_tready_q <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (sts_i.clear_done) begin
            state_q    <= ST_IDLE;
            s_tready_q <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q    <= ST_EXEC;
            s_tready_q <= 1'b0;
          end
        end
        ST_EXEC: begin
          state_q    <= ST_OUT;
          m_tvalid_q <= 1'b1;
        end
        ST_OUT: begin
          if (m_tready_i) begin
            state_q    <= ST_IDLE;
            m_tvalid_q <= 1'b0;
            s_tready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= ST_CLEAR;
          s_tready_q <= 1'b0;
          m_tvalid_q <= 1'b0;
        end
      endcase
    end
  end

  // Commands to the datapath
  always_comb begin
    cmd_o.clear  = (state_q == ST_CLEAR);
    cmd_o.accept = accept;
    cmd_o.load   = (state_q == ST_EXEC);
  end

  assign s_tready_o = s_tready_q;
  assign m_tvalid_o = m_tvalid_q;

  // One access in flight: never taking input while a result is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_tready_o && m_tvalid_o))
    else $error("input ready while result pending");

  // An accepted access is executed in the next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> cmd_o.load)
    else $error("accepted access not executed");

  // No access taken during the clearing pass
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |-> !cmd_o.accept)
    else $error("access accepted during clearing pass");

endmodule

@@ rtl/core/sio_cfg_dp.sv @@
// Datapath of the Super I/O configuration port: lock/index/device state,
// global and banked device register memories, routing shadows, result register.
// Depends on sio_cfg_pkg; driven by sio_cfg_ctrl.
`timescale 1ns / 1ps

module sio_cfg_dp #(
  parameter int unsigned NUM_DEVICES      = 4,
  parameter int unsigned DEVICE_REG_COUNT = 208
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sio_cfg_pkg::cmd_t                   cmd_i,
  output sio_cfg_pkg::sts_t                   sts_o,
  input  logic                                cfg_we_i,
  input  logic [sio_cfg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sio_cfg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [sio_cfg_pkg::IN_TDATA_W-1:0]  in_tdata_i,
  input  logic [sio_cfg_pkg::IN_TUSER_W-1:0]  in_tuser_i,
  output logic [sio_cfg_pkg::OUT_TDATA_W-1:0] out_tdata_o,
  output logic                                out_tuser_o
);

  localparam int unsigned DEV_DEPTH = NUM_DEVICES * DEVICE_REG_COUNT;
  localparam int unsigned DEV_AW    = $clog2(DEV_DEPTH);
  localparam int unsigned DSW       = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam logic [DEV_AW-1:0] CLR_LAST = DEV_AW'(DEV_DEPTH - 1);

  // Configuration registers
  sio_cfg_pkg::byte_t vendor_q, revision_q, lock_key_q, unlock_key_q;

  // Access state
  logic               locked_q;
  sio_cfg_pkg::byte_t index_q;
  sio_cfg_pkg::byte_t dev_sel_q;

  // Routing shadows of registers 0x30, 0x60, 0x61, 0x70 per device
  sio_cfg_pkg::byte_t act_q   [NUM_DEVICES];
  sio_cfg_pkg::byte_t bhi_q   [NUM_DEVICES];
  sio_cfg_pkg::byte_t blo_q   [NUM_DEVICES];
  logic [3:0]         irq_q   [NUM_DEVICES];

  // Memories
  sio_cfg_pkg::byte_t dev_mem [DEV_DEPTH];
  sio_cfg_pkg::byte_t glb_mem [sio_cfg_pkg::GLOBAL_REG_COUNT];
  sio_cfg_pkg::byte_t dev_rd_q, glb_rd_q;

  // Clearing pass address
  logic [DEV_AW-1:0] clr_cnt_q;

  // Captured access
  logic item_func_q, item_port_q, dev_region_q, dev_ok_q, route_hit_q;
  logic id_vendor_q, id_rev_q;

  // Result register
  logic [sio_cfg_pkg::OUT_TDATA_W-1:0] out_tdata_q;
  logic                                out_tuser_q;

  // Decode of the incoming access against current state
  logic               in_func, in_port;
  sio_cfg_pkg::byte_t in_data;
  sio_cfg_pkg::byte_t off;
  logic               dev_region, dev_ok;
  logic [DSW-1:0]     dev_num;
  logic [DEV_AW-1:0]  dev_addr;
  logic               wr_data_port, dev_wr, glb_wr, idx_wr;

  always_comb begin
    in_func      = in_tuser_i[0];
    in_port      = in_tuser_i[1];
    in_data      = in_tdata_i;
    off          = index_q - sio_cfg_pkg::DEV_BASE;
    dev_region   = (index_q >= sio_cfg_pkg::DEV_BASE);
    dev_ok       = dev_region && (dev_sel_q < 8'(NUM_DEVICES))
                   && (off < 8'(DEVICE_REG_COUNT));
    dev_num      = dev_sel_q[DSW-1:0];
    dev_addr     = DEV_AW'(DEV_AW'(dev_num) * DEV_AW'(DEVICE_REG_COUNT)) + DEV_AW'(off);
    wr_data_port = cmd_i.accept && in_func && in_port && !locked_q;
    dev_wr       = wr_data_port && dev_ok;
    glb_wr       = wr_data_port && !dev_region
                   && (index_q != sio_cfg_pkg::REG_VENDOR)
                   && (index_q != sio_cfg_pkg::REG_REVISION);
    idx_wr       = cmd_i.accept && in_func && !in_port;
  end

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vendor_q     <= '0;
      revision_q   <= '0;
      lock_key_q   <= sio_cfg_pkg::LOCK_KEY_RST;
      unlock_key_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sio_cfg_pkg::CFG_VENDOR_ID:   vendor_q     <= cfg_wdata_i;
        sio_cfg_pkg::CFG_REVISION_ID: revision_q   <= cfg_wdata_i;
        sio_cfg_pkg::CFG_LOCK_KEY:    lock_key_q   <= cfg_wdata_i;
        sio_cfg_pkg::CFG_UNLOCK_KEY:  unlock_key_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Lock, index and logical device select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q  <= 1'b1;
      index_q   <= '0;
      dev_sel_q <= '0;
    end else begin
      if (idx_wr) begin
        index_q <= in_data;
        if (in_data == unlock_key_q) begin
          locked_q <= 1'b0;
        end else if (in_data == lock_key_q) begin
          locked_q <= 1'b1;
        end
      end
      if (glb_wr && (index_q == sio_cfg_pkg::REG_LDN)) begin
        dev_sel_q <= in_data;
      end
    end
  end

  // Routing shadows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_DEVICES; i++) begin
        act_q[i] <= '0;
        bhi_q[i] <= '0;
        blo_q[i] <= '0;
        irq_q[i] <= '0;
      end
    end else if (dev_wr) begin
      if (index_q == sio_cfg_pkg::REG_ACTIVATE) act_q[dev_num] <= in_data;
      if (index_q == sio_cfg_pkg::REG_BASE_HI)  bhi_q[dev_num] <= in_data;
      if (index_q == sio_cfg_pkg::REG_BASE_LO)  blo_q[dev_num] <= in_data;
      if (index_q == sio_cfg_pkg::REG_IRQ)      irq_q[dev_num] <= in_data[3:0];
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign sts_o.clear_done = (clr_cnt_q == CLR_LAST);

  // Device register memory: one write port, one registered read port
  logic               dev_we;
  logic [DEV_AW-1:0]  dev_waddr;
  sio_cfg_pkg::byte_t dev_wdata;

  always_comb begin
    dev_we    = cmd_i.clear || dev_wr;
    dev_waddr = cmd_i.clear ? clr_cnt_q : dev_addr;
    dev_wdata = cmd_i.clear ? '0 : in_data;
  end

  always_ff @(posedge clk_i) begin
    if (dev_we) begin
      dev_mem[dev_waddr] <= dev_wdata;
    end
    dev_rd_q <= dev_mem[dev_addr];
  end

  // Global register memory; register 0x22 clears to all ones
  logic                               glb_we;
  logic [sio_cfg_pkg::GLB_AW-1:0]     glb_waddr;
  sio_cfg_pkg::byte_t                 glb_wdata;

  always_comb begin
    glb_we    = (cmd_i.clear && (clr_cnt_q < DEV_AW'(sio_cfg_pkg::GLOBAL_REG_COUNT)))
                || glb_wr;
    glb_waddr = cmd_i.clear ? clr_cnt_q[sio_cfg_pkg::GLB_AW-1:0]
                            : index_q[sio_cfg_pkg::GLB_AW-1:0];
    if (cmd_i.clear) begin
      glb_wdata = (clr_cnt_q == DEV_AW'(sio_cfg_pkg::REG_GLB_FF)) ? sio_cfg_pkg::GLB_FF_RST
                                                                 : '0;
    end else begin
      glb_wdata = in_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (glb_we) begin
      glb_mem[glb_waddr] <= glb_wdata;
    end
    glb_rd_q <= glb_mem[index_q[sio_cfg_pkg::GLB_AW-1:0]];
  end

  // Capture the decoded access
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_func_q  <= 1'b0;
      item_port_q  <= 1'b0;
      dev_region_q <= 1'b0;
      dev_ok_q     <= 1'b0;
      route_hit_q  <= 1'b0;
      id_vendor_q  <= 1'b0;
      id_rev_q     <= 1'b0;
    end else if (cmd_i.accept) begin
      item_func_q  <= in_func;
      item_port_q  <= in_port;
      dev_region_q <= dev_region;
      dev_ok_q     <= dev_ok;
      route_hit_q  <= dev_wr;
      id_vendor_q  <= (index_q == sio_cfg_pkg::REG_VENDOR);
      id_rev_q     <= (index_q == sio_cfg_pkg::REG_REVISION);
    end
  end

  // Result formation
  sio_cfg_pkg::byte_t rd_data;
  logic [15:0]        r_base;
  logic [3:0]         r_irq;
  logic [1:0]         r_dev;
  logic               r_en;

  always_comb begin
    rd_data = '0;
    r_base  = '0;
    r_irq   = '0;
    r_dev   = '0;
    r_en    = 1'b0;
    if (!item_func_q) begin
      if (!item_port_q) begin
        rd_data = index_q;
      end else if (dev_region_q) begin
        rd_data = dev_ok_q ? dev_rd_q : '0;
      end else if (id_vendor_q) begin
        rd_data = vendor_q;
      end else if (id_rev_q) begin
        rd_data = revision_q;
      end else begin
        rd_data = glb_rd_q;
      end
    end
    if (route_hit_q) begin
      r_base = {bhi_q[dev_num], blo_q[dev_num]};
      r_irq  = irq_q[dev_num];
      r_dev  = dev_sel_q[1:0];
      r_en   = (act_q[dev_num] != '0) && (r_base != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_tdata_q <= {1'b0, r_irq, r_base, r_en, r_dev, rd_data};
      out_tuser_q <= route_hit_q;
    end
  end

  assign out_tdata_o = out_tdata_q;
  assign out_tuser_o = out_tuser_q;

  // Unlock key on the index port always opens the block
  a_unlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_wr && (in_data == unlock_key_q) |=> !locked_q)
    else $error("unlock key did not unlock");

  // A routing update only comes from an unlocked, in-range data-port write
  a_route_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && route_hit_q |-> item_func_q && item_port_q && dev_ok_q && !locked_q)
    else $error("routing update from an invalid access");

endmodule

@@ rtl/core/superio_config_port.sv @@
// Top level of the Super I/O index/data configuration port.
// Instantiates sio_cfg_ctrl (sequencer) and sio_cfg_dp (state, memories, result).
// Depends on sio_cfg_pkg.
//
//  Channel  | Direction | Payload                                        | Transfer
//  ---------+-----------+------------------------------------------------+-------------------
//  s_axis   | in        | tdata: write_data; tuser: func, port_select    | tvalid & tready
//  m_axis   | out       | tdata: read_data .. route_irq; tuser: route_vld| tvalid & tready
//  cfg      | in        | cfg_index_i selects register, cfg_wdata_i data | cfg_we_i
//
// Each access goes through transfer in, execute and result offered;
// the next access is taken the cycle after the result transfer.
// The device register memory has one read port; its registered read sets the
// execute cycle between transfer in and result.
// After reset a clearing pass over the NUM_DEVICES * DEVICE_REG_COUNT (832 by default)
// device entries zeroes the memories but writes all ones to global 0x22; s_axis_tready
// stays low until it ends. A stalled result holds m_axis_tvalid and blocks the next access.
`timescale 1ns / 1ps

module superio_config_port #(
  parameter int unsigned NUM_DEVICES      = 4,
  parameter int unsigned DEVICE_REG_COUNT = 208
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // write_data[7:0]
  input  logic [sio_cfg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // func[0], port_select[1]
  input  logic [sio_cfg_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // read_data[7:0], route_device[9:8], route_enable[10], route_base[26:11],
  // route_irq[30:27], zero[31]
  output logic [sio_cfg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // route_valid
  output logic                                m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [sio_cfg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sio_cfg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  sio_cfg_pkg::cmd_t cmd;
  sio_cfg_pkg::sts_t sts;

  sio_cfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sio_cfg_dp #(
    .NUM_DEVICES      (NUM_DEVICES),
    .DEVICE_REG_COUNT (DEVICE_REG_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .out_tdata_o (m_axis_tdata),
    .out_tuser_o (m_axis_tuser)
  );

endmodule
